[design/povlcs_pkg.sv]
// ----------------------------------------------------------------------------
// POV LED column sequencer package
// Shared constants, codes and types for the sweep sequencer and its channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package povlcs_pkg;

   // Sizing
   localparam int unsigned PATTERN_DEPTH = 1024;
   localparam int unsigned CHAR_COUNT    = 16;
   localparam int unsigned SLOT_COUNT    = CHAR_COUNT * 16;
   localparam int unsigned SCROLL_COLS   = CHAR_COUNT * 8;

   localparam int unsigned ADDR_W = $clog2(PATTERN_DEPTH);
   localparam int unsigned LEN_W  = $clog2(PATTERN_DEPTH + 1);
   localparam int unsigned SLOT_W = $clog2(SLOT_COUNT);
   localparam int unsigned TICK_W = 20;
   localparam int unsigned WAIT_W = 20;
   localparam int unsigned CP_W   = 16;
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned OP_W   = 2;

   // Configuration port
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 20;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_DELAY = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_PERIOD  = 2'd2;

   localparam logic [TICK_W-1:0] SHORT_LIMIT_RST = 20'd50000;
   localparam logic [WAIT_W-1:0] START_DELAY_RST = 20'd34000;
   localparam logic [CP_W-1:0]   COL_PERIOD_RST  = 16'd143;

   // Request opcodes
   localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
   localparam logic [OP_W-1:0] OP_PULSE  = 2'd1;
   localparam logic [OP_W-1:0] OP_APPEND = 2'd2;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

   // Sweep phases
   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_WAIT = 2'd1;
   localparam logic [1:0] PH_RUN  = 2'd2;

   localparam logic [BYTE_W-1:0] LED_OFF = 8'hff;

   // Output queue
   localparam int unsigned OUT_DEPTH = 4;
   localparam int unsigned OPTR_W    = $clog2(OUT_DEPTH);
   localparam int unsigned OCNT_W    = $clog2(OUT_DEPTH + 1);

   // Slot issued to the second stage
   typedef struct packed {
      logic odd;      // drives pattern data
      logic inrange;  // read address below the pattern length
      logic last;     // closing all-off word follows
   } slot_type;

   typedef struct packed {
      logic [BYTE_W-1:0] led_byte;
      logic              sweep_end;
   } out_word_type;

endpackage

[design/povlcs_req_if.sv]
// ----------------------------------------------------------------------------
// POV sequencer request channel
// Valid/ready channel carrying one opcode and one pattern byte per word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface povlcs_req_if
   import povlcs_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   opcode;
   logic [BYTE_W-1:0] data_byte;

   modport source (output valid, output opcode, output data_byte, input ready);
   modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

[design/povlcs_rsp_if.sv]
// ----------------------------------------------------------------------------
// POV sequencer response channel
// Valid/ready channel carrying one LED port write per word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface povlcs_rsp_if
   import povlcs_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] led_byte;
   logic              sweep_end;

   modport source (output valid, output led_byte, output sweep_end, input ready);
   modport sink   (input valid, input led_byte, input sweep_end, output ready);
endinterface

[design/povlcs_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module povlcs_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/pov_led_column_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// POV LED column sequencer
// A tick that fires a slot gives its word through the state update and pattern
// read register, then the output queue; on the last slot the closing word
// enters the queue with it. Throughput: one request word per cycle, limited
// only by the four-word output queue when the response side stalls.
// Reset (synchronous): registers take defaults, pattern length cleared,
// interval counter saturated, sweep idle. Pattern memory is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pov_led_column_sequencer_unit
   import povlcs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   povlcs_req_if.sink            req_port,
   povlcs_rsp_if.source          rsp_port,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Configuration registers
   logic [TICK_W-1:0] short_limit_ff;
   logic [WAIT_W-1:0] start_delay_ff;
   logic [CP_W-1:0]   col_period_ff;

   // Sweep state
   logic [LEN_W-1:0]  pattern_length_ff, pattern_length_in;
   logic [TICK_W-1:0] ticks_ff, ticks_in;
   logic [1:0]        phase_ff, phase_in;
   logic [WAIT_W-1:0] wait_ff, wait_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [LEN_W-1:0]  read_index_ff, read_index_in;
   logic [LEN_W-1:0]  scroll_ff, scroll_in;
   logic              scrolling_ff, scrolling_in;

   // Second stage and output queue
   logic              b_valid_ff, b_valid_in;
   slot_type          b_slot_ff, b_slot_in;
   out_word_type      queue_ff [OUT_DEPTH];
   logic [OPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [OCNT_W-1:0] count_ff;

   logic              accept;
   logic [LEN_W-1:0]  ri_sel;
   logic [LEN_W-1:0]  scroll_inc;
   logic              ram_wr_en, ram_rd_en;
   logic [BYTE_W-1:0] ram_rd_data;
   logic [1:0]        b_words;
   logic              pop;
   out_word_type      slot_word, end_word;

   // Request side: room for the worst case of two words behind what is queued
   assign b_words = b_valid_ff ? (b_slot_ff.last ? 2'd2 : 2'd1) : 2'd0;
   assign req_port.ready =
      ({1'b0, count_ff} + {{(OCNT_W-1){1'b0}}, b_words}) <= (OCNT_W+1)'(OUT_DEPTH - 2);
   assign accept = req_port.valid && req_port.ready;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         short_limit_ff <= SHORT_LIMIT_RST;
         start_delay_ff <= START_DELAY_RST;
         col_period_ff  <= COL_PERIOD_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SHORT_LIMIT: short_limit_ff <= csr_wdata[TICK_W-1:0];
            CSR_START_DELAY: start_delay_ff <= csr_wdata[WAIT_W-1:0];
            CSR_COL_PERIOD:  col_period_ff  <= csr_wdata[CP_W-1:0];
            default: ;
         endcase
      end
   end

   // Read index after the scroll wrap, and the next scroll offset
   assign ri_sel = (scrolling_ff && (read_index_ff > pattern_length_ff)) ? '0 : read_index_ff;
   assign scroll_inc = scroll_ff + 1'b1;

   // Next state for one request word
   always_comb begin
      pattern_length_in = pattern_length_ff;
      ticks_in          = ticks_ff;
      phase_in          = phase_ff;
      wait_in           = wait_ff;
      slot_in           = slot_ff;
      read_index_in     = read_index_ff;
      scroll_in         = scroll_ff;
      scrolling_in      = scrolling_ff;
      b_valid_in        = 1'b0;
      b_slot_in         = '0;
      ram_wr_en         = 1'b0;
      ram_rd_en         = 1'b0;
      if (accept) begin
         case (req_port.opcode)
            OP_TICK: begin
               if (ticks_ff != '1) begin
                  ticks_in = ticks_ff + 1'b1;
               end
               if (phase_ff != PH_IDLE) begin
                  if (wait_ff > WAIT_W'(1)) begin
                     wait_in = wait_ff - 1'b1;
                  end else begin
                     // Fire a slot
                     b_valid_in        = 1'b1;
                     b_slot_in.odd     = slot_ff[0];
                     b_slot_in.inrange = ri_sel < pattern_length_ff;
                     ram_rd_en         = slot_ff[0];
                     read_index_in     = slot_ff[0] ? ri_sel + 1'b1 : ri_sel;
                     wait_in           = {{(WAIT_W-CP_W){1'b0}}, col_period_ff};
                     phase_in          = PH_RUN;
                     if (slot_ff == SLOT_W'(SLOT_COUNT - 1)) begin
                        b_slot_in.last = 1'b1;
                        phase_in       = PH_IDLE;
                        slot_in        = '0;
                        wait_in        = '0;
                     end else begin
                        slot_in = slot_ff + 1'b1;
                     end
                  end
               end
            end
            OP_PULSE: begin
               ticks_in = '0;
               if ((ticks_ff >= short_limit_ff) && (phase_ff == PH_IDLE)) begin
                  if (32'(pattern_length_ff) > SCROLL_COLS) begin
                     scrolling_in = 1'b1;
                     scroll_in    = (scroll_inc > pattern_length_ff) ? '0 : scroll_inc;
                  end else begin
                     scrolling_in = 1'b0;
                     scroll_in    = '0;
                  end
                  read_index_in = scroll_in;
                  slot_in       = '0;
                  wait_in       = start_delay_ff;
                  phase_in      = PH_WAIT;
               end
            end
            OP_APPEND: begin
               if (pattern_length_ff < LEN_W'(PATTERN_DEPTH)) begin
                  ram_wr_en         = 1'b1;
                  pattern_length_in = pattern_length_ff + 1'b1;
               end
            end
            OP_CLEAR: begin
               pattern_length_in = '0;
            end
            default: ;
         endcase
      end
   end

   // Pattern memory
   povlcs_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (PATTERN_DEPTH)
   ) u_pattern_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (pattern_length_ff[ADDR_W-1:0]),
      .wr_data (req_port.data_byte),
      .rd_en   (ram_rd_en),
      .rd_addr (ri_sel[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff <= '0;
         ticks_ff          <= '1;
         phase_ff          <= PH_IDLE;
         wait_ff           <= '0;
         slot_ff           <= '0;
         read_index_ff     <= '0;
         scroll_ff         <= '0;
         scrolling_ff      <= 1'b0;
         b_valid_ff        <= 1'b0;
      end else begin
         pattern_length_ff <= pattern_length_in;
         ticks_ff          <= ticks_in;
         phase_ff          <= phase_in;
         wait_ff           <= wait_in;
         slot_ff           <= slot_in;
         read_index_ff     <= read_index_in;
         scroll_ff         <= scroll_in;
         scrolling_ff      <= scrolling_in;
         b_valid_ff        <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      b_slot_ff <= b_slot_in;
   end

   // Words formed from the registered pattern byte
   always_comb begin
      slot_word.sweep_end = 1'b0;
      slot_word.led_byte  = LED_OFF;
      if (b_slot_ff.odd && b_slot_ff.inrange) begin
         slot_word.led_byte = ~ram_rd_data;
      end
      end_word.led_byte  = LED_OFF;
      end_word.sweep_end = 1'b1;
   end

   // Output queue
   assign pop            = rsp_port.valid && rsp_port.ready;
   assign rsp_port.valid = count_ff != '0;
   assign rsp_port.led_byte  = queue_ff[rd_ptr_ff].led_byte;
   assign rsp_port.sweep_end = queue_ff[rd_ptr_ff].sweep_end;

   always_ff @(posedge clock) begin
      if (b_valid_ff) begin
         queue_ff[wr_ptr_ff] <= slot_word;
         if (b_slot_ff.last) begin
            queue_ff[wr_ptr_ff + 1'b1] <= end_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + OPTR_W'(b_words);
         rd_ptr_ff <= rd_ptr_ff + OPTR_W'(pop);
         count_ff  <= count_ff + OCNT_W'(b_words) - OCNT_W'(pop);
      end
   end

endmodule
